@@ hw/rtl/tfps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Triac firing pulse scheduler package
// Shared types, codes and arithmetic constants for the scheduler blocks.
// ----------------------------------------------------------------------------
package tfps_pkg;

    // Mains half cycle length in timer ticks.
    localparam int unsigned HALF_PERIOD_TICKS = 20000;
    localparam logic [15:0] HALF_TICKS = 16'(HALF_PERIOD_TICKS);

    // Field widths.
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned DEG_W   = 8;
    localparam int unsigned CMP_W   = 16;
    localparam int unsigned CODE_W  = 2;

    // Request function codes on the input word.
    localparam logic [FUNC_W-1:0] FUNC_EVENT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEG   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PCT   = 2'd2;

    // Clamp limits and divisors.
    localparam logic [DEG_W-1:0] DEG_SPAN  = 8'd180;
    localparam logic [DEG_W-1:0] DEG_LIMIT = 8'd160;
    localparam logic [DEG_W-1:0] PCT_LIMIT = 8'd100;

    // Division by a constant as a multiply by a rounded-up reciprocal.
    // With products below 2^23 both reciprocals give the exact quotient.
    localparam int unsigned RECIP_SHIFT = 30;
    localparam int unsigned RECIP_W     = 24;
    localparam int unsigned PROD_W      = DEG_W + CMP_W;
    localparam logic [RECIP_W-1:0] RECIP_180 =
        RECIP_W'(((1 << RECIP_SHIFT) + 179) / 180);
    localparam logic [RECIP_W-1:0] RECIP_100 =
        RECIP_W'(((1 << RECIP_SHIFT) + 99) / 100);

    // Depth of the queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Kind of a queued word.
    typedef enum logic [1:0] {
        KIND_EVENT = 2'd0,
        KIND_DEG   = 2'd1,
        KIND_PCT   = 2'd2
    } t_kind;

    // Timer output mode codes.
    typedef enum logic [CODE_W-1:0] {
        MODE_NONE     = 2'd0,
        MODE_INACTIVE = 2'd1,
        MODE_TOGGLE   = 2'd2
    } t_mode;

    // Request status codes.
    typedef enum logic [CODE_W-1:0] {
        STATUS_EVENT    = 2'd0,
        STATUS_ACCEPTED = 2'd1,
        STATUS_BUSY     = 2'd2
    } t_status;

    // Classified and clamped word passed from front to back.
    typedef struct packed {
        t_kind            kind;
        logic [DEG_W-1:0] angle;
        logic [DEG_W-1:0] width;
        logic             gate;
    } t_item;

    // Back sequencer states.
    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_C0   = 3'd1,
        S_MUL  = 3'd2,
        S_DIV  = 3'd3,
        S_LOAD = 3'd4
    } t_state;

endpackage
`default_nettype wire

@@ hw/rtl/tfps_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts input words, drops unused codes, clamps set requests and
// pushes the classified word into the queue.
// ----------------------------------------------------------------------------
module tfps_front import tfps_pkg::*; (
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire logic [DEG_W-1:0]  i_angle,
    input  wire logic [DEG_W-1:0]  i_width,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_item                  o_item
);

    logic [DEG_W-1:0] deg_width;
    logic [DEG_W:0]   deg_sum;

    // Degree request: width limit, then angle plus width limit.
    assign deg_width = (i_width >= DEG_LIMIT) ? DEG_LIMIT : i_width;
    assign deg_sum   = {1'b0, i_angle} + {1'b0, deg_width};

    // A word is taken whenever the queue has room.
    assign o_in_ready = !i_q_full;

    // Classify and clamp.
    always_comb begin
        o_push = 1'b0;
        o_item = '{kind: KIND_EVENT, angle: i_angle, width: i_width, gate: 1'b0};
        unique case (i_func)
            FUNC_EVENT: begin
                o_push = i_in_valid && !i_q_full;
            end
            FUNC_DEG: begin
                o_push       = i_in_valid && !i_q_full;
                o_item.kind  = KIND_DEG;
                o_item.width = deg_width;
                if (deg_sum >= {1'b0, DEG_LIMIT}) begin
                    o_item.angle = DEG_LIMIT - deg_width;
                    o_item.gate  = 1'b0;
                end else begin
                    o_item.gate  = 1'b1;
                end
            end
            FUNC_PCT: begin
                o_push       = i_in_valid && !i_q_full;
                o_item.kind  = KIND_PCT;
                o_item.angle = (i_angle >= DEG_SPAN) ? DEG_SPAN : i_angle;
                o_item.width = (i_width >= PCT_LIMIT) ? PCT_LIMIT : i_width;
            end
            default: begin
                // Unused code: taken and dropped without a result.
                o_push = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/tfps_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler work queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module tfps_queue import tfps_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);

    t_item             r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/tfps_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler back end
// Steps the four-phase compare cycle on events and computes the pending
// compare set for accepted requests with a shared multiply sequencer.
// ----------------------------------------------------------------------------
module tfps_back import tfps_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire t_item             i_q_item,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [CMP_W-1:0]       o_compare_value,
    output logic [CODE_W-1:0]      o_mode_change,
    output logic [CODE_W-1:0]      o_request_status
);

    localparam int unsigned WIDE_W = PROD_W + RECIP_W;

    // Scheduler state.
    t_state           r_state,  n_state;
    logic [1:0]       r_phase,  n_phase;
    logic [CMP_W-1:0] r_active  [4];
    logic [CMP_W-1:0] n_active  [4];
    logic [CMP_W-1:0] r_pending [4];
    logic [CMP_W-1:0] n_pending [4];
    logic             r_pend_valid, n_pend_valid;
    logic             r_gate,   n_gate;

    // Request job registers.
    logic             r_is_deg,   n_is_deg;
    logic [DEG_W-1:0] r_width,    n_width;
    logic             r_gate_new, n_gate_new;
    logic [PROD_W-1:0] r_prod,    n_prod;
    logic [CMP_W-1:0] r_c0,       n_c0;
    logic [CMP_W-1:0] r_quo,      n_quo;

    // Output register.
    logic             r_out_valid, n_out_valid;
    logic [CMP_W-1:0] r_out_cmp,   n_out_cmp;
    t_mode            r_out_mode,  n_out_mode;
    t_status          r_out_stat,  n_out_stat;

    logic              out_free;
    logic [PROD_W-1:0] mul_a;
    logic [CMP_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [RECIP_W-1:0] div_recip;
    logic [WIDE_W-1:0] div_p;
    logic [CMP_W-1:0]  div_q;
    logic [CMP_W-1:0]  c1;

    assign out_free = !r_out_valid || i_out_ready;

    // Shared small multiplier: angle or width times full or remaining ticks.
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Reciprocal multiplier for the constant divisions.
    assign div_recip = (r_state == S_C0 || r_is_deg) ? RECIP_180 : RECIP_100;
    assign div_p     = WIDE_W'(r_prod) * WIDE_W'(div_recip);
    assign div_q     = div_p[RECIP_SHIFT +: CMP_W];

    assign c1 = r_c0 + r_quo;

    // Next state and datapath.
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_active     = r_active;
        n_pending    = r_pending;
        n_pend_valid = r_pend_valid;
        n_gate       = r_gate;
        n_is_deg     = r_is_deg;
        n_width      = r_width;
        n_gate_new   = r_gate_new;
        n_prod       = r_prod;
        n_c0         = r_c0;
        n_quo        = r_quo;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_cmp    = r_out_cmp;
        n_out_mode   = r_out_mode;
        n_out_stat   = r_out_stat;
        o_pop        = 1'b0;
        mul_a        = PROD_W'(i_q_item.angle);
        mul_b        = HALF_TICKS;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop = 1'b1;
                    unique case (i_q_item.kind)
                        KIND_EVENT: begin
                            // Compare match: take in a pending set at phase zero.
                            n_out_valid = 1'b1;
                            n_out_stat  = STATUS_EVENT;
                            n_phase     = r_phase + 2'd1;
                            if (r_pend_valid && r_phase == 2'd0) begin
                                n_active     = r_pending;
                                n_pend_valid = 1'b0;
                                n_out_cmp    = r_pending[0];
                                n_out_mode   = r_gate ? MODE_TOGGLE : MODE_INACTIVE;
                            end else begin
                                n_out_cmp    = r_active[r_phase];
                                n_out_mode   = MODE_NONE;
                            end
                        end
                        KIND_DEG, KIND_PCT: begin
                            if (r_pend_valid) begin
                                // A set still waits: reject without change.
                                n_out_valid = 1'b1;
                                n_out_cmp   = '0;
                                n_out_mode  = MODE_NONE;
                                n_out_stat  = STATUS_BUSY;
                            end else begin
                                n_is_deg   = (i_q_item.kind == KIND_DEG);
                                n_width    = i_q_item.width;
                                n_gate_new = i_q_item.gate;
                                n_prod     = mul_p;
                                n_state    = S_C0;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_C0: begin
                // First edge offset: angle * ticks / 180.
                n_c0    = div_q;
                n_state = S_MUL;
            end
            S_MUL: begin
                // Width product over the full half cycle or the remainder.
                mul_a   = PROD_W'(r_width);
                mul_b   = r_is_deg ? HALF_TICKS : (HALF_TICKS - r_c0);
                n_prod  = mul_p;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_quo   = div_q;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // Store the pending set and report acceptance.
                if (out_free) begin
                    n_pending[0] = r_c0;
                    n_pending[1] = c1;
                    n_pending[2] = r_c0 + HALF_TICKS;
                    n_pending[3] = c1 + HALF_TICKS;
                    n_pend_valid = 1'b1;
                    if (r_is_deg) begin
                        n_gate = r_gate_new;
                    end
                    n_out_valid = 1'b1;
                    n_out_cmp   = '0;
                    n_out_mode  = MODE_NONE;
                    n_out_stat  = STATUS_ACCEPTED;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and scheduler state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= '0;
            r_active     <= '{default: '0};
            r_pending    <= '{default: '0};
            r_pend_valid <= 1'b0;
            r_gate       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_active     <= n_active;
            r_pending    <= n_pending;
            r_pend_valid <= n_pend_valid;
            r_gate       <= n_gate;
            r_out_valid  <= n_out_valid;
        end
    end

    // Job and output payload registers.
    always_ff @(posedge i_clk) begin
        r_is_deg   <= n_is_deg;
        r_width    <= n_width;
        r_gate_new <= n_gate_new;
        r_prod     <= n_prod;
        r_c0       <= n_c0;
        r_quo      <= n_quo;
        r_out_cmp  <= n_out_cmp;
        r_out_mode <= n_out_mode;
        r_out_stat <= n_out_stat;
    end

    assign o_out_valid      = r_out_valid;
    assign o_compare_value  = r_out_cmp;
    assign o_mode_change    = r_out_mode;
    assign o_request_status = r_out_stat;

endmodule
`default_nettype wire

@@ hw/rtl/triac_firing_pulse_scheduler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Triac firing pulse scheduler
// Phase-angle gate pulse scheduler: set requests compute four timer compare
// values, compare-match events step a four-phase cycle and emit them.
//
//   Channel  Handshake                 Word fields
//   input    i_in_valid / o_in_ready   i_func, i_angle, i_width
//   output   o_out_valid / i_out_ready o_compare_value, o_mode_change,
//                                      o_request_status
//
// An event or a rejected request is handled in the idle state of the back
// end; an accepted request steps through the C0, MUL, DIV and LOAD states
// of the shared sequencer. A two-word queue lets the front keep taking words
// while the back works or the output register waits. Reset is synchronous
// and clears the phase, both compare sets, the pending flag and the gate.
// ----------------------------------------------------------------------------
module triac_firing_pulse_scheduler import tfps_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire logic [DEG_W-1:0]  i_angle,
    input  wire logic [DEG_W-1:0]  i_width,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [CMP_W-1:0]       o_compare_value,
    output logic [CODE_W-1:0]      o_mode_change,
    output logic [CODE_W-1:0]      o_request_status
);

    logic  q_full;
    logic  q_push;
    t_item q_in_item;
    logic  q_pop;
    logic  q_valid;
    t_item q_out_item;

    // Front end: classify and clamp.
    tfps_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_angle    (i_angle),
        .i_width    (i_width),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_item     (q_in_item)
    );

    // Queue between the two ends.
    tfps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out_item)
    );

    // Back end: phase cycle and compare computation.
    tfps_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_item         (q_out_item),
        .o_pop            (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_compare_value  (o_compare_value),
        .o_mode_change    (o_mode_change),
        .o_request_status (o_request_status)
    );

endmodule
`default_nettype wire

@@ test/triac_firing_pulse_scheduler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triac firing pulse scheduler testbench
// Drives directed and random compare-match events and set requests through
// the valid/ready input channel, with random gaps on both channels, and
// checks every output word against a scoreboard that tracks the phase, the
// active and pending compare sets, the pending flag and the gate enable.
// ----------------------------------------------------------------------------
module triac_firing_pulse_scheduler_tb;
    import tfps_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int unsigned RANDOM_WORDS = 1000;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = 20;

    // One expected output word.
    typedef struct {
        logic [CMP_W-1:0] value;
        t_mode            mode;
        t_status          status;
    } fire_result_t;

    // Scoreboard: predicts the output word of each accepted input word and
    // checks the output words in order.
    class firing_scoreboard;
        logic [1:0]       phase;
        logic [CMP_W-1:0] active_set[4];
        logic [CMP_W-1:0] pending_set[4];
        bit               pending_full;
        bit               gate_on;
        fire_result_t     due_results[$];
        int unsigned      mismatches;

        function new();
            phase        = '0;
            pending_full = 1'b0;
            gate_on      = 1'b0;
            mismatches   = 0;
            foreach (active_set[i]) begin
                active_set[i]  = '0;
                pending_set[i] = '0;
            end
        endfunction

        // Note an accepted input word and queue the word it should produce.
        function void schedule_word(logic [FUNC_W-1:0] func, logic [DEG_W-1:0] angle,
                                    logic [DEG_W-1:0] width);
            fire_result_t res;
            int unsigned  a;
            int unsigned  w;
            int unsigned  c0;
            int unsigned  c1;
            int unsigned  r;
            // A compare-match event takes in a pending set only at phase zero.
            if (func == FUNC_EVENT) begin
                res.mode = MODE_NONE;
                if (pending_full && phase == 2'd0) begin
                    active_set   = pending_set;
                    res.mode     = gate_on ? MODE_TOGGLE : MODE_INACTIVE;
                    pending_full = 1'b0;
                end
                res.value  = active_set[phase];
                res.status = STATUS_EVENT;
                phase      = phase + 2'd1;
                due_results.push_back(res);
                return;
            end
            // The unused selector produces nothing.
            if (func != FUNC_DEG && func != FUNC_PCT)
                return;
            res.value = '0;
            res.mode  = MODE_NONE;
            // A request while a set waits is rejected and changes nothing.
            if (pending_full) begin
                res.status = STATUS_BUSY;
                due_results.push_back(res);
                return;
            end
            a = angle;
            w = width;
            if (func == FUNC_DEG) begin
                if (w >= DEG_LIMIT)
                    w = DEG_LIMIT;
                if (a + w >= DEG_LIMIT) begin
                    a       = DEG_LIMIT - w;
                    gate_on = 1'b0;
                end else begin
                    gate_on = 1'b1;
                end
                c0 = a * HALF_PERIOD_TICKS / DEG_SPAN;
                c1 = c0 + w * HALF_PERIOD_TICKS / DEG_SPAN;
            end else begin
                if (a >= DEG_SPAN)
                    a = DEG_SPAN;
                if (w >= PCT_LIMIT)
                    w = PCT_LIMIT;
                c0 = a * HALF_PERIOD_TICKS / DEG_SPAN;
                r  = w * (HALF_PERIOD_TICKS - c0) / PCT_LIMIT;
                c1 = c0 + r;
            end
            pending_set[0] = CMP_W'(c0);
            pending_set[1] = CMP_W'(c1);
            pending_set[2] = CMP_W'(c0 + HALF_PERIOD_TICKS);
            pending_set[3] = CMP_W'(c1 + HALF_PERIOD_TICKS);
            pending_full   = 1'b1;
            res.status     = STATUS_ACCEPTED;
            due_results.push_back(res);
        endfunction

        // Compare an output word with the oldest expected word.
        function void check_result(logic [CMP_W-1:0] value, logic [CODE_W-1:0] mode,
                                   logic [CODE_W-1:0] status);
            fire_result_t want;
            if (due_results.size() == 0) begin
                $error("output word with none expected: compare_value %0d", value);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (value !== want.value) begin
                $error("compare_value: expected %0d, actual %0d", want.value, value);
                mismatches++;
            end
            if (mode !== want.mode) begin
                $error("mode_change: expected %0d, actual %0d", want.mode, mode);
                mismatches++;
            end
            if (status !== want.status) begin
                $error("request_status: expected %0d, actual %0d", want.status, status);
                mismatches++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [FUNC_W-1:0] i_func;
    logic [DEG_W-1:0]  i_angle;
    logic [DEG_W-1:0]  i_width;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [CMP_W-1:0]  o_compare_value;
    logic [CODE_W-1:0] o_mode_change;
    logic [CODE_W-1:0] o_request_status;

    firing_scoreboard sb = new();
    int unsigned      words_sent = 0;
    int unsigned      cycles = 0;
    bit               calm = 1'b0;

    triac_firing_pulse_scheduler dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_angle          (i_angle),
        .i_width          (i_width),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_compare_value  (o_compare_value),
        .o_mode_change    (o_mode_change),
        .o_request_status (o_request_status)
    );

    always #5 i_clk = ~i_clk;

    // Give up if the run hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Mostly no gap, some short ones and a few long ones; none in calm stretches.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Angle or width value biased toward the clamp boundaries.
    function automatic logic [DEG_W-1:0] pick_degrees();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return DEG_W'($urandom_range(0, 255));
        if (r < 70)
            return DEG_W'($urandom_range(0, 100));
        if (r < 85)
            return DEG_W'($urandom_range(150, 200));
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd99;
            3:       return 8'd100;
            4:       return 8'd159;
            5:       return 8'd160;
            6:       return 8'd179;
            7:       return 8'd180;
            8:       return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // Offer one input word after a random gap and wait for it to be taken.
    task automatic send_word(input logic [FUNC_W-1:0] func, input logic [DEG_W-1:0] angle,
                             input logic [DEG_W-1:0] width);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_angle    <= angle;
        i_width    <= width;
        do @(posedge i_clk); while (!o_in_ready);
        sb.schedule_word(func, angle, width);
        if (func != FUNC_UNUSED)
            words_sent++;
    endtask

    // Compare-match events with random don't-care payload.
    task automatic send_events(input int unsigned count);
        repeat (count) send_word(FUNC_EVENT, DEG_W'($urandom), DEG_W'($urandom));
    endtask

    // Output side: random stalls on ready.
    initial begin
        int unsigned stall;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(posedge i_clk);
        end
    end

    // Check every word that leaves the block.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_compare_value, o_mode_change, o_request_status);
    end

    // Stimulus.
    initial begin
        int unsigned stop_at;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_func     <= FUNC_EVENT;
        i_angle    <= '0;
        i_width    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Event with nothing pending at phase zero, then the unused selector.
        send_events(1);
        send_word(FUNC_UNUSED, 8'hFF, 8'hFF);
        // Zero request accepted, then a busy degree and a busy percent request.
        send_word(FUNC_DEG, 8'd0, 8'd0);
        send_word(FUNC_DEG, 8'd255, 8'd255);
        send_word(FUNC_PCT, 8'd10, 8'd10);
        // Phases one to three keep the old set; phase zero takes in the new one.
        send_events(7);
        // Full-scale degree request clamps and disables the gate.
        send_word(FUNC_DEG, 8'd255, 8'd255);
        send_events(4);
        // Angle plus width just below the limit enables the gate.
        send_word(FUNC_DEG, 8'd100, 8'd59);
        send_events(4);
        // Full-scale percent request clamps and keeps the gate bit.
        send_word(FUNC_PCT, 8'd255, 8'd255);
        send_events(4);

        // Random part: mostly a request followed by events, some noise.
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at) begin
            calm = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) < 7) begin
                send_word(FUNC_W'($urandom_range(FUNC_DEG, FUNC_PCT)), pick_degrees(),
                          pick_degrees());
                send_events($urandom_range(1, 8));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_word(FUNC_W'($urandom_range(0, 3)), pick_degrees(), pick_degrees());
            end
        end
        i_in_valid <= 1'b0;

        // Drain the remaining words, then let the block settle.
        while (sb.due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
